FILE: rtl/can_signal_extractor_assert.svh
// ----------------------------------------------------------------------------
// can_signal_extractor_assert.svh
// Assertion macros shared by the signal extractor RTL.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACTOR_ASSERT_SVH
`define CAN_SIGNAL_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSX_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csx assertion failed");

// next-cycle implication, checked out of reset
`define CSX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csx assertion failed");

`endif

FILE: rtl/csx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_pkg
// Types, constants and bit-ordering helpers for the CAN signal extractor.
// ----------------------------------------------------------------------------
package csx_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int START_W       = 6;
  localparam int LEN_W         = 7;
  localparam int SCALE_W       = 32;
  localparam int OFFSET_W      = 48;
  localparam int PHYS_W        = 64;
  localparam int VALUE_W       = PAYLOAD_W + 1;   // field as exact signed value
  localparam int PP_W          = VALUE_W;         // 33 x 32 partial product
  localparam int SUM_W         = 98;              // full product plus offset

  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(PAYLOAD_W);
  localparam logic [PHYS_W-1:0] PHYS_MAX = {1'b0, {(PHYS_W-1){1'b1}}};
  localparam logic [PHYS_W-1:0] PHYS_MIN = {1'b1, {(PHYS_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ORD_INTEL     = 3'b001,
    ORD_MOTO_MSB  = 3'b010,
    ORD_MOTO_SWAP = 3'b100
  } order_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0]       payload;
    logic [START_W-1:0]         start_bit;
    logic [LEN_W-1:0]           bit_length;
    logic                       little_endian;
    logic                       is_signed;
    logic signed [SCALE_W-1:0]  scale_q16;
    logic signed [OFFSET_W-1:0] offset_q16;
  } item_t;

  // after the aligning shift
  typedef struct packed {
    logic [PAYLOAD_W-1:0]       field;
    logic [LEN_W-1:0]           len;
    order_t                     order;
    logic                       sgn;
    logic signed [SCALE_W-1:0]  scale;
    logic signed [OFFSET_W-1:0] offset;
    logic                       beyond;
  } align_t;

  // field reordered and turned into an exact signed value
  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic signed [SCALE_W-1:0]  scale;
    logic signed [OFFSET_W-1:0] offset;
    logic                       beyond;
  } ext_t;

  typedef struct packed {
    logic signed [PP_W-1:0]     pp_hi;
    logic signed [PP_W-1:0]     pp_lo;
    logic signed [OFFSET_W-1:0] offset;
    logic [PAYLOAD_W-1:0]       raw_bits;
    logic                       beyond;
  } prod_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0]     raw_bits;
    logic signed [PHYS_W-1:0] phys_q16;
    logic                     saturated;
    logic                     beyond_frame;
  } res_t;

  // full 64-bit bit reversal
  function automatic logic [PAYLOAD_W-1:0] bit_rev(input logic [PAYLOAD_W-1:0] d);
    logic [PAYLOAD_W-1:0] r;
    for (int i = 0; i < PAYLOAD_W; i++) begin
      r[i] = d[PAYLOAD_W-1-i];
    end
    return r;
  endfunction

  // reverse the bits inside each byte, bytes stay in place
  function automatic logic [PAYLOAD_W-1:0] byte_bit_rev(input logic [PAYLOAD_W-1:0] d);
    logic [PAYLOAD_W-1:0] r;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      for (int j = 0; j < 8; j++) begin
        r[8*k+j] = d[8*k+7-j];
      end
    end
    return r;
  endfunction

  // reverse the byte order
  function automatic logic [PAYLOAD_W-1:0] byte_swap(input logic [PAYLOAD_W-1:0] d);
    logic [PAYLOAD_W-1:0] r;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      r[8*k +: 8] = d[8*(PAYLOAD_BYTES-1-k) +: 8];
    end
    return r;
  endfunction

endpackage

FILE: rtl/csx_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_item_if
// Input channel: payload plus signal descriptor, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csx_item_if;
  import csx_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [PAYLOAD_W-1:0]       payload;
  logic [START_W-1:0]         start_bit;
  logic [LEN_W-1:0]           bit_length;
  logic                       little_endian;
  logic                       is_signed;
  logic signed [SCALE_W-1:0]  scale_q16;
  logic signed [OFFSET_W-1:0] offset_q16;

  modport source (
    output valid, payload, start_bit, bit_length, little_endian, is_signed,
           scale_q16, offset_q16,
    input  ready
  );

  modport sink (
    input  valid, payload, start_bit, bit_length, little_endian, is_signed,
           scale_q16, offset_q16,
    output ready
  );
endinterface

FILE: rtl/csx_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_result_if
// Result channel: raw field, physical value and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csx_result_if;
  import csx_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PAYLOAD_W-1:0]     raw_bits;
  logic signed [PHYS_W-1:0] phys_q16;
  logic                     saturated;
  logic                     beyond_frame;

  modport source (
    output valid, raw_bits, phys_q16, saturated, beyond_frame,
    input  ready
  );

  modport sink (
    input  valid, raw_bits, phys_q16, saturated, beyond_frame,
    output ready
  );
endinterface

FILE: rtl/csx_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_extract
// Two stages: align the field to bit 0, then reorder and sign-extend it.
// ----------------------------------------------------------------------------
module csx_extract (
  input  logic            clk,
  input  logic            rst,
  input  logic            msb_first,
  input  logic            in_valid,
  output logic            in_ready,
  input  csx_pkg::item_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output csx_pkg::ext_t   out_data
);
  import csx_pkg::*;

  logic   v1, v2;
  logic   ready1, ready2;
  align_t s1, s1_next;
  ext_t   s2, s2_next;

  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // ---- stage 1: aligning shift
  logic [LEN_W-1:0]     len_c;
  logic                 moto;
  logic [START_W-1:0]   shamt;
  logic [PAYLOAD_W-1:0] src, shifted, mask;
  logic [LEN_W-1:0]     end_pos;

  always_comb begin
    len_c = (in_data.bit_length > LEN_MAX) ? LEN_MAX : in_data.bit_length;
    moto  = !in_data.little_endian && msb_first;
    // Motorola: bit-reverse each byte so the downward walk becomes upward
    shamt = moto ? {in_data.start_bit[START_W-1:3], ~in_data.start_bit[2:0]}
                 : in_data.start_bit;
    src     = moto ? byte_bit_rev(in_data.payload) : in_data.payload;
    shifted = src >> shamt;
    mask    = ~({PAYLOAD_W{1'b1}} << len_c);
    end_pos = LEN_W'(shamt) + len_c;

    s1_next.field  = shifted & mask;
    s1_next.len    = len_c;
    s1_next.sgn    = in_data.is_signed;
    s1_next.scale  = in_data.scale_q16;
    s1_next.offset = in_data.offset_q16;
    s1_next.beyond = (len_c != '0) && (end_pos > LEN_MAX);
    if (in_data.little_endian) begin
      s1_next.order = ORD_INTEL;
    end else if (msb_first) begin
      s1_next.order = ORD_MOTO_MSB;
    end else begin
      s1_next.order = ORD_MOTO_SWAP;
    end
  end

  // ---- stage 2: reorder and exact signed value
  logic [PAYLOAD_W-1:0] raw;
  logic [LEN_W-1:0]     len_m1, len_rnd;
  logic [3:0]           nbytes;
  logic                 neg;
  logic [VALUE_W-1:0]   bias;

  always_comb begin
    len_rnd = s1.len + LEN_W'(7);
    nbytes  = len_rnd[LEN_W-1:3];
    case (s1.order)
      ORD_INTEL:     raw = s1.field;
      ORD_MOTO_MSB:  raw = bit_rev(s1.field) >> (LEN_MAX - s1.len);
      ORD_MOTO_SWAP: raw = byte_swap(s1.field) >> {4'd8 - nbytes, 3'b000};
      default:       raw = s1.field;
    endcase
    len_m1 = s1.len - LEN_W'(1);
    neg    = s1.sgn && (s1.len != '0) && raw[len_m1[START_W-1:0]];
    bias   = neg ? (VALUE_W'(1) << s1.len) : '0;

    s2_next.value  = $signed({1'b0, raw} - bias);
    s2_next.scale  = s1.scale;
    s2_next.offset = s1.offset;
    s2_next.beyond = s1.beyond;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
    if (ready1 && in_valid) s1 <= s1_next;
    if (ready2 && v1)       s2 <= s2_next;
  end

  assign out_valid = v2;
  assign out_data  = s2;

`include "can_signal_extractor_assert.svh"

  `CSX_ASSERT_IMPLY(a_len_zero_empty, v1 && s1.len == '0, s1.field == '0 && !s1.beyond)
  `CSX_ASSERT_NEXT(a_unsigned_nonneg, v1 && ready2 && !s1.sgn, !s2.value[VALUE_W-1])
  `CSX_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v1)

endmodule

FILE: rtl/csx_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csx_mac
// Two stages: split 65x32 multiply, then sum with offset and saturate.
// ----------------------------------------------------------------------------
module csx_mac (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  csx_pkg::ext_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csx_pkg::res_t  out_data
);
  import csx_pkg::*;

  logic  v3, v4;
  logic  ready3, ready4;
  prod_t s3, s3_next;
  res_t  s4, s4_next;

  assign ready4   = !v4 || out_ready;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  // ---- stage 3: two 33x32 partial products
  logic signed [32:0] val_hi;
  logic signed [32:0] val_lo;

  always_comb begin
    val_hi = in_data.value[VALUE_W-1:32];
    val_lo = $signed({1'b0, in_data.value[31:0]});
    s3_next.pp_hi    = PP_W'(val_hi * in_data.scale);
    s3_next.pp_lo    = PP_W'(val_lo * in_data.scale);
    s3_next.offset   = in_data.offset;
    s3_next.raw_bits = in_data.value[PAYLOAD_W-1:0];
    s3_next.beyond   = in_data.beyond;
  end

  // ---- stage 4: combine, add offset, clip to 64-bit signed
  logic signed [SUM_W-1:0] sum;
  logic                    fits;

  always_comb begin
    sum = $signed({s3.pp_hi[PP_W-1], s3.pp_hi, 32'd0})
        + SUM_W'(s3.pp_lo) + SUM_W'(s3.offset);
    fits = (&sum[SUM_W-1:PHYS_W-1]) || !(|sum[SUM_W-1:PHYS_W-1]);
    s4_next.raw_bits     = s3.raw_bits;
    s4_next.saturated    = !fits;
    s4_next.beyond_frame = s3.beyond;
    if (fits) begin
      s4_next.phys_q16 = sum[PHYS_W-1:0];
    end else if (sum[SUM_W-1]) begin
      s4_next.phys_q16 = PHYS_MIN;
    end else begin
      s4_next.phys_q16 = PHYS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready3) v3 <= in_valid;
      if (ready4) v4 <= v3;
    end
    if (ready3 && in_valid) s3 <= s3_next;
    if (ready4 && v3)       s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_data  = s4;

`include "can_signal_extractor_assert.svh"

  `CSX_ASSERT_IMPLY(a_sat_at_bound, v4 && s4.saturated, s4.phys_q16 == PHYS_MAX || s4.phys_q16 == PHYS_MIN)
  `CSX_ASSERT_IMPLY(a_empty_out_ready, !v4, in_ready)

endmodule

FILE: rtl/can_signal_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_extractor
// Pulls one DBC-style signal out of an 8-byte CAN payload and scales it.
// ----------------------------------------------------------------------------
// Usage:
//   item   : payload plus signal descriptor (start bit, length, byte order,
//            signedness, Q16.16 scale, Q32.16 offset); valid/ready.
//   result : raw field, saturated Q48.16 physical value, saturated and
//            beyond_frame flags; valid/ready.
//   cfg_we / cfg_wdata : writes motorola_start_msb (reset 1). Write only
//            while no transfer is in flight.
// Timing:
//   Four register stages: align shift, reorder + sign, partial products,
//   sum + saturate. One transfer per cycle sustained while result.ready
//   stays high; the final stage is the output register.
// Reset: all stage valid bits clear, the register returns to 1.
// Stall: each stage holds while the one after it is full and stalled, so
//   bubbles still fill and item.ready stays high until all four are full.
// ----------------------------------------------------------------------------
module can_signal_extractor (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  csx_item_if.sink     item,
  csx_result_if.source result
);
  import csx_pkg::*;

  // motorola_start_msb: 1 = start bit is the MSB, 0 = Intel read + byte swap
  logic motorola_start_msb;

  always_ff @(posedge clk) begin
    if (rst) begin
      motorola_start_msb <= 1'b1;
    end else if (cfg_we) begin
      motorola_start_msb <= cfg_wdata;
    end
  end

  item_t in_data;
  ext_t  ext_data;
  res_t  res_data;
  logic  ext_valid, ext_ready;

  always_comb begin
    in_data.payload       = item.payload;
    in_data.start_bit     = item.start_bit;
    in_data.bit_length    = item.bit_length;
    in_data.little_endian = item.little_endian;
    in_data.is_signed     = item.is_signed;
    in_data.scale_q16     = item.scale_q16;
    in_data.offset_q16    = item.offset_q16;
  end

  // field extraction: stages 1 and 2
  csx_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .msb_first (motorola_start_msb),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_data   (in_data),
    .out_valid (ext_valid),
    .out_ready (ext_ready),
    .out_data  (ext_data)
  );

  // scale, offset, saturate: stages 3 and 4
  csx_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ext_valid),
    .in_ready  (ext_ready),
    .in_data   (ext_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (res_data)
  );

  assign result.raw_bits     = res_data.raw_bits;
  assign result.phys_q16     = res_data.phys_q16;
  assign result.saturated    = res_data.saturated;
  assign result.beyond_frame = res_data.beyond_frame;

endmodule
